@@ rtl/word_count_hash_table_defines.svh @@
// Assertion macros for the RTL of the word counting hash table.
`ifndef WORD_COUNT_HASH_TABLE_DEFINES_SVH
`define WORD_COUNT_HASH_TABLE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define WCHT_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition in one cycle that implies another condition in the next cycle.
`define WCHT_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/wcht_pkg.sv @@
package wcht_pkg;

  localparam int SLOTS         = 1024;
  localparam int SLOT_BITS     = 10;
  localparam int MAX_WORD      = 32;
  localparam int LEN_BITS      = 6;
  localparam int DOCS          = 100;
  localparam int DOC_BITS      = 7;
  localparam int COUNT_BITS    = 16;
  localparam int KEY_BITS      = 27;
  localparam int TS_BITS       = 11;
  localparam int SB_BITS       = 10;
  localparam int CNT_DEPTH     = SLOTS * DOCS;
  localparam int CNT_ADDR_BITS = 17;
  localparam int ROW_BITS      = MAX_WORD * 8;
  localparam int HASH_BITS     = 32;
  localparam int MOD_CNT_BITS  = 6;
  localparam logic [KEY_BITS-1:0] KEY_MOD = KEY_BITS'(100000000);
  // The hash over the key modulus is at most 42, so six compare and subtract
  // steps reduce it; the upper 26 hash bits are already below the modulus.
  localparam int KEY_STEPS     = 6;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_TABLE_SIZE = 2'd0;
  localparam logic [1:0] REG_PROBE_MODE = 2'd1;
  localparam logic [1:0] REG_SKIP_BASE  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_NEW  = 2'd0;
  localparam logic [1:0] ST_OLD  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_LONG = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FIN,
    S_MOD,
    S_PROBE_RD,
    S_PROBE_EV,
    S_ADDR,
    S_CRD,
    S_CUPD,
    S_OUT
  } state_t;

  // What the shared remainder unit is currently working out.
  typedef enum logic [1:0] {
    OP_KEY,
    OP_HOME,
    OP_SKIP,
    OP_STEP
  } mod_op_t;

endpackage

@@ rtl/word_count_hash_table.sv @@
// Word counting hash table.
// Input channel (char_valid / char_stall): one character per beat, with
// last_char marking the end of a word and doc_index naming its document.
// Each non-final character is hashed and buffered as it is taken. A final
// character starts the lookup: the hash is finalized, one shared restoring
// remainder unit reduces it to the key in six compare and subtract steps,
// then works out the home slot and, in double hashing mode, the probe step.
// Each probe then takes a table read state and a compare state, and a count
// update takes an address, a read and an update state. char_stall stays high
// through the lookup. Long words and a full table skip the probe walk.
// Output channel (result_valid / result_stall): one beat per word with the
// status, slot, count and key. A result waiting on a stalled receiver does
// not block the next word; that word's lookup runs and then waits to load.
// Reset clears the control state and then runs a pass over all 1024 slots
// that marks every slot free; char_stall is high during that pass. Configuration
// writes (cfg_we, cfg_index, cfg_data) are taken at any time.
`include "word_count_hash_table_defines.svh"

module word_count_hash_table (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [wcht_pkg::TS_BITS-1:0]   cfg_data,
  input  logic                           char_valid,
  output logic                           char_stall,
  input  logic [7:0]                     char_code,
  input  logic                           last_char,
  input  logic [wcht_pkg::DOC_BITS-1:0]  doc_index,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [1:0]                     status,
  output logic [wcht_pkg::SLOT_BITS-1:0] slot,
  output logic [wcht_pkg::COUNT_BITS-1:0] doc_count,
  output logic [wcht_pkg::KEY_BITS-1:0]  word_key
);

  // Configuration registers.
  logic [wcht_pkg::TS_BITS-1:0] table_size;
  logic                         probe_mode;
  logic [wcht_pkg::SB_BITS-1:0] skip_base;

  wcht_pkg::state_t state, state_next;

  // Word assembly.
  logic [wcht_pkg::HASH_BITS-1:0] hash_accum;
  logic [wcht_pkg::LEN_BITS-1:0]  word_length;
  logic [wcht_pkg::ROW_BITS-1:0]  word_buf;
  logic [wcht_pkg::DOC_BITS-1:0]  doc;

  // Shared remainder unit.
  logic [wcht_pkg::HASH_BITS-1:0]    md_num;
  logic [wcht_pkg::KEY_BITS-1:0]     md_den;
  logic [wcht_pkg::KEY_BITS-1:0]     md_rem;
  logic [wcht_pkg::MOD_CNT_BITS-1:0] md_cnt;
  wcht_pkg::mod_op_t                 md_op;
  logic [wcht_pkg::KEY_BITS:0]       md_trial;
  logic [wcht_pkg::KEY_BITS-1:0]     md_rem_next;

  // Lookup state.
  logic [wcht_pkg::KEY_BITS-1:0]      key;
  logic [wcht_pkg::SLOT_BITS-1:0]     idx;
  logic [wcht_pkg::SLOT_BITS-1:0]     step;
  logic [wcht_pkg::TS_BITS-1:0]       probes;
  logic [wcht_pkg::TS_BITS-1:0]       key_count;
  logic [wcht_pkg::SLOT_BITS-1:0]     clr_idx;
  logic                               claim;
  logic [wcht_pkg::DOCS-1:0]          dv_row;
  logic [wcht_pkg::CNT_ADDR_BITS-1:0] cnt_addr;
  logic [1:0]                         res_status;
  logic [wcht_pkg::SLOT_BITS-1:0]     res_slot;
  logic [wcht_pkg::COUNT_BITS-1:0]    res_count;

  // Memories: slot flags and length, stored words, per-document valid flags
  // and the counts themselves.
  logic [wcht_pkg::LEN_BITS:0]        meta_mem [wcht_pkg::SLOTS];
  logic [wcht_pkg::ROW_BITS-1:0]      word_mem [wcht_pkg::SLOTS];
  logic [wcht_pkg::DOCS-1:0]          dv_mem   [wcht_pkg::SLOTS];
  logic [wcht_pkg::COUNT_BITS-1:0]    cnt_mem  [wcht_pkg::CNT_DEPTH];
  logic [wcht_pkg::LEN_BITS:0]        meta_q;
  logic [wcht_pkg::ROW_BITS-1:0]      word_q;
  logic [wcht_pkg::DOCS-1:0]          dv_q;
  logic [wcht_pkg::COUNT_BITS-1:0]    cnt_q;

  logic                           meta_we, word_we, dv_we, cnt_we, out_load;
  logic [wcht_pkg::SLOT_BITS-1:0] meta_wa;
  logic [wcht_pkg::LEN_BITS:0]    meta_wd;
  logic [wcht_pkg::DOCS-1:0]      dv_wd;

  logic [wcht_pkg::TS_BITS-1:0]   ts_eff;
  logic [wcht_pkg::SB_BITS-1:0]   sb_eff;
  logic                           too_long, doc_ok, slot_used, word_match, table_full;
  logic [wcht_pkg::HASH_BITS-1:0] ch_a, ch_b, ch_h, fin_a, fin_b, fin_h;
  logic [wcht_pkg::TS_BITS-1:0]   idx_sum;
  logic [wcht_pkg::SLOT_BITS-1:0] idx_wrap;
  logic [wcht_pkg::COUNT_BITS-1:0] cnt_old, cnt_new;
  logic                           char_accept;

  // Register values out of range act as their nearest legal value.
  always_comb begin
    if (table_size == '0) begin
      ts_eff = wcht_pkg::TS_BITS'(1);
    end else if (table_size > wcht_pkg::TS_BITS'(wcht_pkg::SLOTS)) begin
      ts_eff = wcht_pkg::TS_BITS'(wcht_pkg::SLOTS);
    end else begin
      ts_eff = table_size;
    end
    sb_eff = (skip_base == '0) ? wcht_pkg::SB_BITS'(1) : skip_base;
  end

  assign char_accept = char_valid && !char_stall;
  assign char_stall  = (state != wcht_pkg::S_IDLE);
  assign too_long    = (word_length > wcht_pkg::LEN_BITS'(wcht_pkg::MAX_WORD));
  assign doc_ok      = (doc < wcht_pkg::DOC_BITS'(wcht_pkg::DOCS));
  assign table_full  = (key_count >= ts_eff);

  // One-at-a-time hash: per-character mix and the final avalanche.
  always_comb begin
    ch_a  = hash_accum + {24'd0, char_code};
    ch_b  = ch_a + (ch_a << 10);
    ch_h  = ch_b ^ (ch_b >> 6);
    fin_a = hash_accum + (hash_accum << 3);
    fin_b = fin_a ^ (fin_a >> 11);
    fin_h = fin_b + (fin_b << 15);
  end

  // One restoring step of the remainder unit.
  always_comb begin
    md_trial = {md_rem, md_num[wcht_pkg::HASH_BITS-1]};
    if (md_trial >= {1'b0, md_den}) begin
      md_rem_next = wcht_pkg::KEY_BITS'(md_trial - {1'b0, md_den});
    end else begin
      md_rem_next = md_trial[wcht_pkg::KEY_BITS-1:0];
    end
  end

  // Probe evaluation. Buffer bytes past the word end are always zero, so the
  // whole row compares.
  assign slot_used  = meta_q[wcht_pkg::LEN_BITS];
  assign word_match = (meta_q[wcht_pkg::LEN_BITS-1:0] == word_length) && (word_q == word_buf);
  assign idx_sum    = {1'b0, idx} + {1'b0, step};
  assign idx_wrap   = (idx_sum >= ts_eff) ? wcht_pkg::SLOT_BITS'(idx_sum - ts_eff)
                                          : idx_sum[wcht_pkg::SLOT_BITS-1:0];

  // Count update with saturation. A document flag that is clear means zero.
  always_comb begin
    cnt_old = (claim || !dv_row[doc]) ? '0 : cnt_q;
    cnt_new = (cnt_old == '1) ? cnt_old : cnt_old + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wcht_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    meta_we    = 1'b0;
    meta_wa    = idx;
    meta_wd    = {1'b1, word_length};
    word_we    = 1'b0;
    dv_we      = 1'b0;
    dv_wd      = '0;
    cnt_we     = 1'b0;
    out_load   = 1'b0;
    case (state)
      wcht_pkg::S_CLEAR: begin
        meta_we = 1'b1;
        meta_wa = clr_idx;
        meta_wd = '0;
        if (clr_idx == wcht_pkg::SLOT_BITS'(wcht_pkg::SLOTS - 1)) begin
          state_next = wcht_pkg::S_IDLE;
        end
      end
      wcht_pkg::S_IDLE: begin
        if (char_valid && last_char) begin
          state_next = wcht_pkg::S_FIN;
        end
      end
      wcht_pkg::S_FIN: begin
        state_next = wcht_pkg::S_MOD;
      end
      wcht_pkg::S_MOD: begin
        if (md_cnt == '0) begin
          case (md_op)
            wcht_pkg::OP_KEY: begin
              state_next = (too_long || table_full) ? wcht_pkg::S_OUT : wcht_pkg::S_MOD;
            end
            wcht_pkg::OP_HOME: begin
              state_next = probe_mode ? wcht_pkg::S_MOD : wcht_pkg::S_PROBE_RD;
            end
            wcht_pkg::OP_SKIP: begin
              state_next = wcht_pkg::S_MOD;
            end
            default: begin
              state_next = wcht_pkg::S_PROBE_RD;
            end
          endcase
        end
      end
      wcht_pkg::S_PROBE_RD: begin
        state_next = (probes >= ts_eff) ? wcht_pkg::S_OUT : wcht_pkg::S_PROBE_EV;
      end
      wcht_pkg::S_PROBE_EV: begin
        if (!slot_used) begin
          meta_we    = 1'b1;
          word_we    = 1'b1;
          dv_we      = 1'b1;
          state_next = doc_ok ? wcht_pkg::S_ADDR : wcht_pkg::S_OUT;
        end else if (word_match) begin
          state_next = doc_ok ? wcht_pkg::S_ADDR : wcht_pkg::S_OUT;
        end else begin
          state_next = wcht_pkg::S_PROBE_RD;
        end
      end
      wcht_pkg::S_ADDR: begin
        state_next = wcht_pkg::S_CRD;
      end
      wcht_pkg::S_CRD: begin
        state_next = wcht_pkg::S_CUPD;
      end
      wcht_pkg::S_CUPD: begin
        cnt_we     = 1'b1;
        dv_we      = 1'b1;
        dv_wd      = dv_row | (wcht_pkg::DOCS'(1) << doc);
        state_next = wcht_pkg::S_OUT;
      end
      wcht_pkg::S_OUT: begin
        if (!result_valid || !result_stall) begin
          out_load   = 1'b1;
          state_next = wcht_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = wcht_pkg::S_IDLE;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= wcht_pkg::TS_BITS'(1021);
      probe_mode <= 1'b0;
      skip_base  <= wcht_pkg::SB_BITS'(510);
    end else if (cfg_we) begin
      case (cfg_index)
        wcht_pkg::REG_TABLE_SIZE: table_size <= cfg_data;
        wcht_pkg::REG_PROBE_MODE: probe_mode <= cfg_data[0];
        wcht_pkg::REG_SKIP_BASE:  skip_base  <= cfg_data[wcht_pkg::SB_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Word assembly: the buffer starts from zero for every word.
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_accum  <= '0;
      word_length <= '0;
      word_buf    <= '0;
    end else if (char_accept) begin
      hash_accum <= ch_h;
      if (word_length < wcht_pkg::LEN_BITS'(wcht_pkg::MAX_WORD)) begin
        word_buf[word_length[wcht_pkg::LEN_BITS-2:0]*8 +: 8] <= char_code;
      end
      if (word_length <= wcht_pkg::LEN_BITS'(wcht_pkg::MAX_WORD)) begin
        word_length <= word_length + 1'b1;
      end
    end else if (out_load) begin
      hash_accum  <= '0;
      word_length <= '0;
      word_buf    <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_accept) begin
      doc <= doc_index;
    end
  end

  // Sequencer datapath: remainder unit, probe walk and result fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      md_cnt    <= '0;
      md_op     <= wcht_pkg::OP_KEY;
      key_count <= '0;
      clr_idx   <= '0;
    end else begin
      case (state)
        wcht_pkg::S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
        end
        wcht_pkg::S_FIN: begin
          // The upper hash bits start as the partial remainder, so only the
          // low bits need compare and subtract steps.
          md_num <= fin_h << (wcht_pkg::HASH_BITS - wcht_pkg::KEY_STEPS);
          md_den <= wcht_pkg::KEY_MOD;
          md_rem <= wcht_pkg::KEY_BITS'(fin_h >> wcht_pkg::KEY_STEPS);
          md_cnt <= wcht_pkg::MOD_CNT_BITS'(wcht_pkg::KEY_STEPS);
          md_op  <= wcht_pkg::OP_KEY;
        end
        wcht_pkg::S_MOD: begin
          if (md_cnt != '0) begin
            md_rem <= md_rem_next;
            md_num <= md_num << 1;
            md_cnt <= md_cnt - 1'b1;
          end else begin
            md_rem <= '0;
            md_cnt <= wcht_pkg::MOD_CNT_BITS'(wcht_pkg::HASH_BITS);
            md_den <= wcht_pkg::KEY_BITS'(ts_eff);
            case (md_op)
              wcht_pkg::OP_KEY: begin
                key        <= md_rem;
                res_status <= too_long ? wcht_pkg::ST_LONG : wcht_pkg::ST_FULL;
                res_slot   <= '0;
                res_count  <= '0;
                probes     <= '0;
                md_num     <= wcht_pkg::HASH_BITS'(md_rem);
                md_op      <= wcht_pkg::OP_HOME;
              end
              wcht_pkg::OP_HOME: begin
                idx    <= md_rem[wcht_pkg::SLOT_BITS-1:0];
                step   <= (ts_eff == wcht_pkg::TS_BITS'(1)) ? '0 : wcht_pkg::SLOT_BITS'(1);
                md_num <= wcht_pkg::HASH_BITS'(key);
                md_den <= wcht_pkg::KEY_BITS'(sb_eff);
                md_op  <= wcht_pkg::OP_SKIP;
              end
              wcht_pkg::OP_SKIP: begin
                md_num <= wcht_pkg::HASH_BITS'(sb_eff - md_rem[wcht_pkg::SB_BITS-1:0]);
                md_op  <= wcht_pkg::OP_STEP;
              end
              default: begin
                step <= md_rem[wcht_pkg::SLOT_BITS-1:0];
              end
            endcase
          end
        end
        wcht_pkg::S_PROBE_EV: begin
          if (!slot_used) begin
            key_count  <= key_count + 1'b1;
            claim      <= 1'b1;
            dv_row     <= '0;
            res_status <= wcht_pkg::ST_NEW;
            res_slot   <= idx;
          end else if (word_match) begin
            claim      <= 1'b0;
            dv_row     <= dv_q;
            res_status <= wcht_pkg::ST_OLD;
            res_slot   <= idx;
          end else begin
            idx    <= idx_wrap;
            probes <= probes + 1'b1;
          end
        end
        wcht_pkg::S_ADDR: begin
          cnt_addr <= wcht_pkg::CNT_ADDR_BITS'(idx) * wcht_pkg::CNT_ADDR_BITS'(wcht_pkg::DOCS)
                      + wcht_pkg::CNT_ADDR_BITS'(doc);
        end
        wcht_pkg::S_CUPD: begin
          res_count <= cnt_new;
        end
        default: ;
      endcase
    end
  end

  // Memories with registered reads.
  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_wa] <= meta_wd;
    end
    meta_q <= meta_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (word_we) begin
      word_mem[idx] <= word_buf;
    end
    word_q <= word_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (dv_we) begin
      dv_mem[idx] <= dv_wd;
    end
    dv_q <= dv_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_addr] <= cnt_new;
    end
    cnt_q <= cnt_mem[cnt_addr];
  end

  // Output register: holds its beat while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status    <= res_status;
      slot      <= res_slot;
      doc_count <= res_count;
      word_key  <= key;
    end
  end

  `WCHT_CHECK(a_key_count_bound, key_count <= wcht_pkg::TS_BITS'(wcht_pkg::SLOTS),
    "more slots claimed than the table holds")
  `WCHT_CHECK(a_probe_in_table, state != wcht_pkg::S_PROBE_EV || {1'b0, idx} < ts_eff,
    "probe index outside the table")
  `WCHT_CHECK(a_rem_below_den, state != wcht_pkg::S_MOD || md_rem < md_den,
    "remainder unit out of range")
  `WCHT_CHECK_NEXT(a_result_from_out, !result_valid && state != wcht_pkg::S_OUT,
    !result_valid, "result raised outside the output state")

endmodule

@@ test/word_count_checker.sv @@
// Watches both channels and the register port of the word counting hash table,
// keeps a private copy of the table, and checks every result beat in order.
module word_count_checker
  import wcht_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [TS_BITS-1:0]    cfg_data,
  input  logic                  char_valid,
  input  logic                  char_stall,
  input  logic [7:0]            char_code,
  input  logic                  last_char,
  input  logic [DOC_BITS-1:0]   doc_index,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  logic [1:0]            status,
  input  logic [SLOT_BITS-1:0]  slot,
  input  logic [COUNT_BITS-1:0] doc_count,
  input  logic [KEY_BITS-1:0]   word_key,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic [1:0]            status;
    logic [SLOT_BITS-1:0]  slot;
    logic [COUNT_BITS-1:0] count;
    logic [KEY_BITS-1:0]   key;
  } word_tally_t;

  word_tally_t awaited_tallies[$];

  logic [TS_BITS-1:0]    size_reg;
  logic                  double_reg;
  logic [SB_BITS-1:0]    skip_reg;
  logic [31:0]           hash_run;
  int                    word_len;
  logic [7:0]            word_buf[MAX_WORD];
  logic                  slot_taken[SLOTS];
  int                    slot_len[SLOTS];
  logic [7:0]            slot_chars[SLOTS][MAX_WORD];
  logic [COUNT_BITS-1:0] doc_tally[SLOTS][DOCS];
  int                    keys_held;

  assign pending = awaited_tallies.size();

  function automatic bit same_word(int s);
    if (slot_len[s] != word_len) return 0;
    for (int i = 0; i < word_len; i++)
      if (slot_chars[s][i] != word_buf[i]) return 0;
    return 1;
  endfunction

  function automatic logic [COUNT_BITS-1:0] bump_doc(int s, int doc);
    if (doc >= DOCS) return '0;
    if (doc_tally[s][doc] != {COUNT_BITS{1'b1}}) doc_tally[s][doc]++;
    return doc_tally[s][doc];
  endfunction

  // Folds one character into the running hash; on the final character it
  // works out the lookup and queues the tally the block should report.
  task automatic fold_char(logic [7:0] c, logic fin, int doc);
    logic [31:0] h;
    int          ts, sb, stride, idx;
    word_tally_t t;
    h = hash_run + c;
    h = h + (h << 10);
    h = h ^ (h >> 6);
    hash_run = h;
    if (word_len < MAX_WORD) word_buf[word_len] = c;
    if (word_len <= MAX_WORD) word_len++;
    if (fin) begin
      h = h + (h << 3);
      h = h ^ (h >> 11);
      h = h + (h << 15);
      t.key = KEY_BITS'(h % 32'd100000000);
      t.status = ST_FULL;
      t.slot = '0;
      t.count = '0;
      ts = (size_reg == 0) ? 1 : ((size_reg > SLOTS) ? SLOTS : int'(size_reg));
      sb = (skip_reg == 0) ? 1 : int'(skip_reg);
      stride = double_reg ? ((sb - int'(t.key) % sb) % ts) : (1 % ts);
      if (word_len > MAX_WORD) begin
        t.status = ST_LONG;
      end else if (keys_held < ts) begin
        idx = int'(t.key) % ts;
        for (int n = 0; n < ts; n++) begin
          if (!slot_taken[idx]) begin
            slot_taken[idx] = 1'b1;
            slot_len[idx] = word_len;
            for (int i = 0; i < word_len; i++) slot_chars[idx][i] = word_buf[i];
            for (int d = 0; d < DOCS; d++) doc_tally[idx][d] = '0;
            keys_held++;
            t.status = ST_NEW;
            t.slot = SLOT_BITS'(idx);
            t.count = bump_doc(idx, doc);
            break;
          end
          if (same_word(idx)) begin
            t.status = ST_OLD;
            t.slot = SLOT_BITS'(idx);
            t.count = bump_doc(idx, doc);
            break;
          end
          idx = (idx + stride) % ts;
        end
      end
      hash_run = '0;
      word_len = 0;
      awaited_tallies.push_back(t);
    end
  endtask

  always @(posedge clk) begin
    word_tally_t w;
    if (rst) begin
      size_reg = 11'd1021;
      double_reg = 1'b0;
      skip_reg = 10'd510;
      hash_run = '0;
      word_len = 0;
      keys_held = 0;
      fail_count = 0;
      awaited_tallies.delete();
      for (int s = 0; s < SLOTS; s++) begin
        slot_taken[s] = 1'b0;
        slot_len[s] = 0;
        for (int d = 0; d < DOCS; d++) doc_tally[s][d] = '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TABLE_SIZE: size_reg = cfg_data;
          REG_PROBE_MODE: double_reg = cfg_data[0];
          REG_SKIP_BASE:  skip_reg = cfg_data[SB_BITS-1:0];
          default: ;
        endcase
      end
      if (char_valid && !char_stall) fold_char(char_code, last_char, int'(doc_index));
      if (result_valid && !result_stall) begin
        if (awaited_tallies.size() == 0) begin
          $display("%0t: result beat with nothing expected: status %0d slot %0d count %0d key %0d",
                   $time, status, slot, doc_count, word_key);
          fail_count++;
        end else begin
          w = awaited_tallies.pop_front();
          if (status !== w.status) begin
            $display("%0t: status expected %0d actual %0d", $time, w.status, status);
            fail_count++;
          end
          if (slot !== w.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, w.slot, slot);
            fail_count++;
          end
          if (doc_count !== w.count) begin
            $display("%0t: doc_count expected %0d actual %0d", $time, w.count, doc_count);
            fail_count++;
          end
          if (word_key !== w.key) begin
            $display("%0t: word_key expected %0d actual %0d", $time, w.key, word_key);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

@@ test/testbench.sv @@
// Top of the word counting hash table bench. It makes the character stream,
// the register writes and the receiver stalls; the checker beside the block
// predicts and compares, and this module only turns its failure count into
// the verdict.
module testbench;
  import wcht_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_index = REG_TABLE_SIZE;
  logic [TS_BITS-1:0]    cfg_data = '0;
  logic                  char_valid = 1'b0;
  logic                  char_stall;
  logic [7:0]            char_code = '0;
  logic                  last_char = 1'b0;
  logic [DOC_BITS-1:0]   doc_index = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [1:0]            status;
  logic [SLOT_BITS-1:0]  slot;
  logic [COUNT_BITS-1:0] doc_count;
  logic [KEY_BITS-1:0]   word_key;
  int                    fail_count;
  int                    pending;
  int                    idle_cycles = 0;

  // Burst state of the sender: beats left in this burst before a gap.
  int                    burst_left = 0;
  int                    chars_sent = 0;

  // A small vocabulary so that random words come back and get counted again.
  logic [7:0]            vocab[24][MAX_WORD];
  int                    vocab_len[24];
  logic [7:0]            spell[64];

  always #2 clk = ~clk;

  word_count_hash_table u_dut (.*);

  word_count_checker u_checker (.*);

  // Watchdog: any cycle in which neither channel moves a beat counts toward
  // the limit. The clearing pass after reset and the long receiver hold both
  // fit well inside it.
  always @(posedge clk) begin
    if ((char_valid && !char_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  // Receiver. It stalls on random patterns, with some stretches of no stall
  // at all. Early on it holds off for a long stretch while the sender keeps
  // going, so results back up and the block stalls the character channel.
  initial begin
    int run;
    int kind;
    @(negedge clk);
    while (rst) @(negedge clk);
    repeat (3000) begin
      result_stall <= ($urandom_range(0, 3) == 0);
      @(negedge clk);
    end
    result_stall <= 1'b1;
    repeat (4000) @(negedge clk);
    forever begin
      run = $urandom_range(5, 300);
      kind = $urandom_range(0, 3);
      repeat (run) begin
        case (kind)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 1) == 0);
          2: result_stall <= ($urandom_range(0, 7) != 0);
          default: result_stall <= ($urandom_range(0, 5) == 0);
        endcase
        @(negedge clk);
      end
    end
  end

  // Offers one character beat, called at a falling edge, and returns at the
  // falling edge after it is taken, or after the gap that follows it. Valid
  // stays high inside a burst; a gap lowers it for a random number of cycles.
  task automatic send_char(logic [7:0] c, logic fin, logic [DOC_BITS-1:0] doc);
    char_valid <= 1'b1;
    char_code <= c;
    last_char <= fin;
    doc_index <= doc;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    @(negedge clk);
    chars_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      if ($urandom_range(0, 2) != 0) begin
        char_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  endtask

  task automatic send_word(int len, logic [DOC_BITS-1:0] doc);
    for (int i = 0; i < len; i++) send_char(spell[i], i == len - 1, doc);
  endtask

  // Lets the block drain completely before a register write.
  task automatic drain;
    char_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  // Drives one register write for the next rising edge; the caller lowers
  // the write enable after the last one.
  task automatic write_reg(logic [1:0] idx, logic [TS_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  task automatic set_table(int ts, int mode, int sb);
    drain();
    write_reg(REG_TABLE_SIZE, TS_BITS'(ts));
    write_reg(REG_PROBE_MODE, TS_BITS'(mode));
    write_reg(REG_SKIP_BASE, TS_BITS'(sb));
    cfg_we <= 1'b0;
  endtask

  // Mostly vocabulary words, some fresh random ones, a few too long. Documents
  // are mostly in range, with some past the last document.
  function automatic logic [DOC_BITS-1:0] pick_doc();
    if ($urandom_range(0, 9) == 0) return DOC_BITS'($urandom_range(DOCS, 127));
    return DOC_BITS'($urandom_range(0, DOCS - 1));
  endfunction

  task automatic random_words(int char_budget);
    int stop_at;
    int len;
    int pick;
    int v;
    stop_at = chars_sent + char_budget;
    while (chars_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        v = $urandom_range(0, 23);
        len = vocab_len[v];
        for (int i = 0; i < len; i++) spell[i] = vocab[v][i];
      end else begin
        len = (pick < 95) ? $urandom_range(1, MAX_WORD) : $urandom_range(MAX_WORD + 1, 45);
        for (int i = 0; i < len; i++) spell[i] = 8'($urandom_range(0, 255));
      end
      send_word(len, pick_doc());
    end
  endtask

  initial begin
    for (int v = 0; v < 24; v++) begin
      vocab_len[v] = (v < 3) ? $urandom_range(20, MAX_WORD) : $urandom_range(1, 10);
      for (int i = 0; i < MAX_WORD; i++) vocab[v][i] = 8'($urandom_range(0, 255));
    end
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words at the reset settings. Character codes at both ends,
    // a word of the maximum length, one just over it, words that share a
    // prefix but differ in length, repeats, and documents past the last one.
    spell[0] = 8'h00;
    send_word(1, 7'd0);
    spell[0] = 8'hFF;
    send_word(1, 7'd99);
    spell[1] = 8'h00;
    send_word(2, 7'd99);
    spell[0] = 8'h00;
    spell[1] = 8'h00;
    send_word(2, 7'd1);
    spell[0] = 8'h00;
    send_word(1, 7'd0);
    for (int i = 0; i < 34; i++) spell[i] = (i % 2 == 0) ? 8'hA5 : 8'h5A;
    send_word(MAX_WORD, 7'd3);
    send_word(MAX_WORD, 7'd3);
    send_word(MAX_WORD + 1, 7'd3);
    send_word(MAX_WORD, 7'd100);
    send_word(MAX_WORD, 7'd127);

    // A tiny table in double mode where some steps are a whole multiple of
    // the table size, so probes run out; it also fills up.
    set_table(17, 1, 17);
    random_words(45);
    // Largest table, linear stepping, widest skip base.
    set_table(SLOTS, 0, 1023);
    random_words(45);
    // Size past the slot count and a zero skip base.
    set_table(2047, 1, 0);
    random_words(45);
    // Smallest skip base in double mode.
    set_table(1021, 1, 1);
    random_words(45);
    // Zero size acts as a single slot, which is already taken.
    set_table(0, 0, 510);
    random_words(15);
    set_table(300, 1, 1023);
    random_words(45);

    drain();
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
